### rtl/core/jbse_pkg.sv
// Shared types and constants of the JPEG block symbol encoder.
// Used by the front, the operation queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jbse_pkg;

  localparam int NUM_COMPONENTS = 4;
  localparam int BLOCK_COEFFS   = 64;
  localparam int QUEUE_DEPTH    = 4;

  localparam int CompIdxW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int PosW     = $clog2(BLOCK_COEFFS);
  localparam int CoefW    = 16;
  localparam int DiffW    = CoefW + 1;
  localparam int RunW     = 4;
  localparam int SizeW    = 5;
  localparam int AmpW     = 17;

  localparam logic [PosW-1:0] LastPos = PosW'(BLOCK_COEFFS - 1);
  localparam logic [RunW-1:0] RunMax  = 4'd15;

  typedef enum logic [1:0] {
    SymDc  = 2'd0,
    SymAc  = 2'd1,
    SymZrl = 2'd2,
    SymEob = 2'd3
  } sym_kind_e;

  typedef enum logic {
    ItemCoef    = 1'b0,
    ItemRestart = 1'b1
  } item_kind_e;

  // One classified item: optional ZRL burst, then one final symbol.
  typedef struct packed {
    sym_kind_e               kind;
    logic [1:0]              table_sel;
    logic [1:0]              zrl_count;
    logic [RunW-1:0]         run;
    logic signed [DiffW-1:0] value;
  } jbse_op_t;

endpackage

`default_nettype wire

### rtl/core/jpeg_block_symbol_encoder.sv
// JPEG baseline run/size symbol coder: top level.
// Instantiates jbse_front, jbse_queue and jbse_back; types from jbse_pkg.
//
// Usage:
//   Input word: kind, coefficient, component, dc_table, ac_table; taken at a
//   clock edge with in_valid_i high and in_stall_o low. Coefficients come in
//   zigzag order, 64 per block; a restart word clears the DC predictors and
//   the block position and yields no symbol.
//   Output word: symbol_kind, table_sel, zero_run, size_category,
//   amplitude_bits and last, taken with out_valid_o high and out_stall_i low.
//   last marks the final symbol caused by one input word.
//   Throughput: one input word per cycle while in_stall_o is low. Each word
//   yields zero or one symbol, except a nonzero AC coefficient after 16 or
//   more zeros, which also yields one ZRL per 16 zeros; the back end issues each ZRL as a symbol of its own.
//   A symbol passes through the queue and then the output register before it
//   appears at the output.
//   A four-entry queue separates the front from the back end; in_stall_o rises
//   only when it is full, so an output stall backs up into the input after
//   the queue and the output register fill.
//   Reset clears predictors, position, zero run, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_block_symbol_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] coefficient_i,
  input  wire logic [1:0]  component_i,
  input  wire logic [1:0]  dc_table_i,
  input  wire logic [1:0]  ac_table_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  symbol_kind_o,
  output      logic [1:0]  table_sel_o,
  output      logic [3:0]  zero_run_o,
  output      logic [4:0]  size_category_o,
  output      logic [16:0] amplitude_bits_o,
  output      logic        last_o
);
  import jbse_pkg::*;

  logic     accept, push, pop, full, empty;
  jbse_op_t op, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jbse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .coefficient_i (coefficient_i),
    .component_i   (component_i),
    .dc_table_i    (dc_table_i),
    .ac_table_i    (ac_table_i),
    .push_o        (push),
    .op_o          (op)
  );

  jbse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  jbse_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .symbol_kind_o    (symbol_kind_o),
    .table_sel_o      (table_sel_o),
    .zero_run_o       (zero_run_o),
    .size_category_o  (size_category_o),
    .amplitude_bits_o (amplitude_bits_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

### rtl/core/jbse_front.sv
// Front end: accepts items, keeps DC predictors, block position and zero run.
// Emits one classified operation per symbol-producing item. Uses jbse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jbse_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic                     kind_i,
  input  wire logic [15:0]              coefficient_i,
  input  wire logic [1:0]               component_i,
  input  wire logic [1:0]               dc_table_i,
  input  wire logic [1:0]               ac_table_i,
  output      logic                     push_o,
  output      jbse_pkg::jbse_op_t       op_o
);
  import jbse_pkg::*;

  logic signed [CoefW-1:0] pred_q [NUM_COMPONENTS];
  logic signed [CoefW-1:0] pred_d [NUM_COMPONENTS];
  logic [PosW-1:0]         pos_q, pos_d;
  logic [PosW-1:0]         zeros_q, zeros_d;
  logic [CompIdxW-1:0]     comp_idx;
  logic signed [CoefW-1:0] coef;
  logic                    is_restart;

  assign comp_idx   = CompIdxW'(32'(component_i) % NUM_COMPONENTS);
  assign coef       = coefficient_i;
  assign is_restart = (item_kind_e'(kind_i) == ItemRestart);

  always_comb begin
    pred_d          = pred_q;
    pos_d           = pos_q;
    zeros_d         = zeros_q;
    push_o          = 1'b0;
    op_o.kind       = SymDc;
    op_o.table_sel  = ac_table_i;
    op_o.zrl_count  = 2'd0;
    op_o.run        = '0;
    op_o.value      = DiffW'(coef);
    if (accept_i) begin
      if (is_restart) begin
        for (int i = 0; i < NUM_COMPONENTS; i++) begin
          pred_d[i] = '0;
        end
        pos_d   = '0;
        zeros_d = '0;
      end else begin
        if (pos_q == '0) begin
          push_o         = 1'b1;
          op_o.kind      = SymDc;
          op_o.table_sel = dc_table_i;
          op_o.value     = DiffW'(coef) - DiffW'(pred_q[comp_idx]);
          pred_d[comp_idx] = coef;
          zeros_d        = '0;
        end else if (coef == '0) begin
          zeros_d = zeros_q + 1'b1;
          if (pos_q == LastPos) begin
            push_o    = 1'b1;
            op_o.kind = SymEob;
          end
        end else begin
          // every 16 pending zeros become one ZRL ahead of the run/size symbol
          push_o         = 1'b1;
          op_o.kind      = SymAc;
          op_o.zrl_count = zeros_q[PosW-1:RunW];
          op_o.run       = zeros_q[RunW-1:0];
          zeros_d        = '0;
        end
        if (pos_q == LastPos) begin
          pos_d   = '0;
          zeros_d = '0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        pred_q[i] <= '0;
      end
      pos_q   <= '0;
      zeros_q <= '0;
    end else begin
      pred_q  <= pred_d;
      pos_q   <= pos_d;
      zeros_q <= zeros_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jbse_queue.sv
// Short register queue of classified operations between front and back end.
// Depth from jbse_pkg::QUEUE_DEPTH; head is visible while not empty.
`timescale 1ns / 1ps
`default_nettype none

module jbse_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire jbse_pkg::jbse_op_t  op_i,
  input  wire logic                pop_i,
  output      logic                full_o,
  output      logic                empty_o,
  output      jbse_pkg::jbse_op_t  head_o
);
  import jbse_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  jbse_op_t        slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jbse_back.sv
// Back end: expands queued operations into symbols, ZRLs first, one a cycle while the output is not stalled.
// Computes size category and amplitude bits; drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module jbse_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                empty_i,
  input  wire jbse_pkg::jbse_op_t  head_i,
  output      logic                pop_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [1:0]          symbol_kind_o,
  output      logic [1:0]          table_sel_o,
  output      logic [3:0]          zero_run_o,
  output      logic [4:0]          size_category_o,
  output      logic [16:0]         amplitude_bits_o,
  output      logic                last_o
);
  import jbse_pkg::*;

  logic             valid_q, valid_d;
  logic [1:0]       zrl_done_q, zrl_done_d;
  logic [1:0]       kind_q, kind_d;
  logic [1:0]       table_q, table_d;
  logic [RunW-1:0]  run_q, run_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [AmpW-1:0]  amp_q, amp_d;
  logic             last_q, last_d;

  logic             load, issue, neg;
  logic [DiffW-1:0] mag, raw, mask;
  logic [SizeW-1:0] size_c;

  assign load  = !valid_q || !out_stall_i;
  assign issue = load && !empty_i;
  assign pop_o = issue && (zrl_done_q == head_i.zrl_count);

  // size category and masked amplitude of the head value
  always_comb begin
    neg    = head_i.value[DiffW-1];
    mag    = neg ? DiffW'(-head_i.value) : DiffW'(head_i.value);
    raw    = neg ? DiffW'(head_i.value - 1'b1) : DiffW'(head_i.value);
    size_c = '0;
    for (int i = 0; i < DiffW; i++) begin
      if (mag[i]) begin
        size_c = SizeW'(i + 1);
      end
    end
    for (int i = 0; i < DiffW; i++) begin
      mask[i] = (SizeW'(i) < size_c);
    end
  end

  always_comb begin
    valid_d    = valid_q;
    zrl_done_d = zrl_done_q;
    kind_d     = kind_q;
    table_d    = table_q;
    run_d      = run_q;
    size_d     = size_q;
    amp_d      = amp_q;
    last_d     = last_q;
    if (load) begin
      valid_d = !empty_i;
    end
    if (issue) begin
      table_d = head_i.table_sel;
      if (!pop_o) begin
        kind_d     = SymZrl;
        run_d      = RunMax;
        size_d     = '0;
        amp_d      = '0;
        last_d     = 1'b0;
        zrl_done_d = zrl_done_q + 1'b1;
      end else begin
        kind_d     = head_i.kind;
        last_d     = 1'b1;
        zrl_done_d = '0;
        unique case (head_i.kind)
          SymDc: begin
            run_d  = '0;
            size_d = size_c;
            amp_d  = AmpW'(raw & mask);
          end
          SymAc: begin
            run_d  = head_i.run;
            size_d = size_c;
            amp_d  = AmpW'(raw & mask);
          end
          default: begin
            run_d  = '0;
            size_d = '0;
            amp_d  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      zrl_done_q <= '0;
    end else begin
      valid_q    <= valid_d;
      zrl_done_q <= zrl_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    table_q <= table_d;
    run_q   <= run_d;
    size_q  <= size_d;
    amp_q   <= amp_d;
    last_q  <= last_d;
  end

  assign out_valid_o      = valid_q;
  assign symbol_kind_o    = kind_q;
  assign table_sel_o      = table_q;
  assign zero_run_o       = run_q;
  assign size_category_o  = size_q;
  assign amplitude_bits_o = amp_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire
